/* rtl/san_pkg.sv */
// Shared package for the spectrum average normalizer.
// Holds sizes, command codes, state encodings and the divider request and response structs.
// No dependencies.
package san_pkg;

   localparam int NUM_BINS = 4096;
   localparam int BIN_W = $clog2(NUM_BINS);
   localparam int CNT_W = BIN_W + 1;
   localparam int SUM_W = 32;
   localparam int MEAN_W = 15;
   localparam int DIM_W = 12;
   localparam int DIV_W = 32;
   localparam logic [MEAN_W-1:0] MIN_START = 15'd9999;
   localparam logic [MEAN_W-1:0] MEAN_MAX = 15'd32767;
   localparam logic [DIM_W-1:0] EDGE_ROWS = 12'd2;

   typedef enum logic [1:0] {
      CMD_ACCUM = 2'd0,
      CMD_END_FRAME = 2'd1,
      CMD_READ = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      REG_WINDOW_START = 2'd0,
      REG_WINDOW_END = 2'd1,
      REG_DISPLAY_WIDTH = 2'd2,
      REG_DISPLAY_HEIGHT = 2'd3
   } reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_ACC_READ,
      ST_ACC_WRITE,
      ST_EF_READ,
      ST_EF_DIV,
      ST_RD_READ,
      ST_RD_MEAN,
      ST_RD_X,
      ST_RD_H,
      ST_DONE
   } state_type;

   // Request to and status from the shared divider.
   typedef struct packed {
      logic start;
      logic [63:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic [63:0] quotient;
   } div_rsp_type;

endpackage

/* rtl/san_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
module san_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Read-first (a read returns the old word on a write to the same address), registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end

endmodule

/* rtl/san_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on san_pkg.
module san_div
   import san_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int STEP_W = $clog2(64 + 1);

   logic [63:0] quot_ff, quot_in;
   logic [DIV_W:0] rem_ff, rem_in;
   logic [DIV_W-1:0] dsr_ff, dsr_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [DIV_W:0] trial;

   // One shift-subtract step per cycle over the 64-bit dividend.
   always_comb begin
      quot_in = quot_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff[DIV_W-1:0], quot_ff[63]};
      if (req.start) begin
         quot_in = req.dividend;
         rem_in = '0;
         dsr_in = req.divisor;
         step_in = STEP_W'(64);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quot_in = {quot_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quot_in = {quot_ff[62:0], 1'b0};
         end
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quotient = quot_ff;

`ifndef ASSERT_OFF
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp.done |-> !rsp.busy)
      else $error("divider done while busy");
   a_done_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp.done |=> !rsp.done)
      else $error("divider done held");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      req.start |=> rsp.busy)
      else $error("divider did not start");
`endif

endmodule

/* rtl/spectrum_average_normalizer_top.sv */
// Top level of the spectrum average normalizer: sequencer, sums RAM, divider.
// Depends on san_pkg, san_ram and san_div.
// Accumulate reads then writes back the bin's sum (nothing outside the window); read runs
// up to three 64-step divisions (mean, x, height); end frame runs one division per window bin;
// clear writes every bin. One command at a time; busy stays high until the command finishes.
// Reset starts a clearing pass over all NUM_BINS sums, during which busy is high.
module spectrum_average_normalizer_top
   import san_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_command,
   input  logic [BIN_W-1:0]    req_bin_index,
   input  logic signed [15:0]  req_sample,
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [12:0]         csr_data,
   output logic                rsp_strobe,
   output logic                rsp_status,
   output logic [DIM_W-1:0]    rsp_x_position,
   output logic [DIM_W-1:0]    rsp_height,
   output logic [MEAN_W-1:0]   rsp_min_mean,
   output logic [MEAN_W-1:0]   rsp_max_mean
);

   state_type state_ff, state_in;
   logic [11:0] wstart_ff;
   logic [12:0] wend_ff;
   logic [DIM_W-1:0] dwidth_ff, dheight_ff;
   logic [15:0] fcount_ff, fcount_in;
   logic [MEAN_W-1:0] wmin_ff, wmin_in, wmax_ff, wmax_in;
   logic [BIN_W-1:0] addr_ff, addr_in;
   logic [15:0] mag_ff, mag_in;
   logic [MEAN_W-1:0] mean_ff, mean_in;
   logic status_ff, status_in;
   logic [DIM_W-1:0] x_ff, x_in, h_ff, h_in;
   logic strobe_ff, strobe_in;
   logic [CNT_W-1:0] eff_end;
   logic [CNT_W-1:0] span;
   logic in_win;
   logic ram_we;
   logic [SUM_W-1:0] ram_wdata, ram_rdata;
   logic [SUM_W:0] acc_sum;
   logic [DIM_W-1:0] usable;
   logic [MEAN_W-1:0] q_mean;
   div_req_type dreq;
   div_rsp_type drsp;
   logic [CNT_W-1:0] last_bin;

   assign eff_end = (wend_ff < 13'(NUM_BINS)) ? CNT_W'(wend_ff) : CNT_W'(NUM_BINS);
   assign span = eff_end - CNT_W'(wstart_ff);
   assign in_win = (CNT_W'(req_bin_index) >= CNT_W'(wstart_ff))
                   && (CNT_W'(req_bin_index) < eff_end);
   assign usable = (dheight_ff >= EDGE_ROWS) ? dheight_ff - EDGE_ROWS : '0;
   assign acc_sum = {1'b0, ram_rdata} + (SUM_W+1)'(mag_ff);
   assign q_mean = (drsp.quotient > 64'(MEAN_MAX)) ? MEAN_MAX : drsp.quotient[MEAN_W-1:0];
   assign last_bin = eff_end - CNT_W'(1);

   san_ram #(.WIDTH(SUM_W), .DEPTH(NUM_BINS)) u_sums (
      .clock(clock), .wr_en(ram_we), .addr(addr_ff),
      .wr_data(ram_wdata), .rd_data(ram_rdata)
   );

   san_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wstart_ff <= '0;
         wend_ff <= 13'd4096;
         dwidth_ff <= 12'd640;
         dheight_ff <= 12'd200;
      end else if (csr_write) begin
         unique case (reg_type'(csr_index))
            REG_WINDOW_START: wstart_ff <= csr_data[11:0];
            REG_WINDOW_END: wend_ff <= csr_data;
            REG_DISPLAY_WIDTH: dwidth_ff <= csr_data[11:0];
            REG_DISPLAY_HEIGHT: dheight_ff <= csr_data[11:0];
         endcase
      end
   end

   // Sequencer: next state and datapath control.
   always_comb begin
      state_in = state_ff;
      fcount_in = fcount_ff;
      wmin_in = wmin_ff;
      wmax_in = wmax_ff;
      addr_in = addr_ff;
      mag_in = mag_ff;
      mean_in = mean_ff;
      status_in = status_ff;
      x_in = x_ff;
      h_in = h_ff;
      strobe_in = 1'b0;
      ram_we = 1'b0;
      ram_wdata = '0;
      dreq = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               addr_in = req_bin_index;
               mag_in = req_sample[15] ? 16'(-req_sample) : 16'(req_sample);
               status_in = 1'b0;
               x_in = '0;
               h_in = '0;
               mean_in = '0;
               unique case (cmd_type'(req_command))
                  CMD_ACCUM: state_in = in_win ? ST_ACC_READ : ST_IDLE;
                  CMD_CLEAR: begin
                     fcount_in = '0;
                     wmin_in = MIN_START;
                     wmax_in = '0;
                     addr_in = '0;
                     state_in = ST_CLEAR;
                  end
                  CMD_END_FRAME: begin
                     if (fcount_ff != 16'hFFFF) fcount_in = fcount_ff + 16'd1;
                     wmin_in = MIN_START;
                     wmax_in = '0;
                     addr_in = wstart_ff;
                     state_in = (CNT_W'(wstart_ff) < eff_end) ? ST_EF_READ : ST_DONE;
                  end
                  CMD_READ: begin
                     if (in_win) begin
                        state_in = ST_RD_READ;
                     end else begin
                        status_in = 1'b1;
                        state_in = ST_DONE;
                     end
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            ram_we = 1'b1;
            addr_in = addr_ff + BIN_W'(1);
            if (addr_ff == BIN_W'(NUM_BINS - 1)) state_in = ST_IDLE;
         end
         ST_ACC_READ: state_in = ST_ACC_WRITE;
         ST_ACC_WRITE: begin
            ram_we = 1'b1;
            ram_wdata = acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];
            state_in = ST_IDLE;
         end
         ST_EF_READ: state_in = ST_EF_DIV;
         ST_EF_DIV: begin
            if (!drsp.busy && !drsp.done) begin
               dreq.start = 1'b1;
               dreq.dividend = 64'(ram_rdata);
               dreq.divisor = 32'(fcount_ff);
            end
            if (drsp.done) begin
               if (q_mean > wmax_ff) wmax_in = q_mean;
               if (q_mean < wmin_ff) wmin_in = q_mean;
               if (CNT_W'(addr_ff) == last_bin) begin
                  state_in = ST_DONE;
               end else begin
                  addr_in = addr_ff + BIN_W'(1);
                  state_in = ST_EF_READ;
               end
            end
         end
         ST_RD_READ: state_in = (fcount_ff == '0) ? ST_RD_X : ST_RD_MEAN;
         ST_RD_MEAN: begin
            if (!drsp.busy && !drsp.done) begin
               dreq.start = 1'b1;
               dreq.dividend = 64'(ram_rdata);
               dreq.divisor = 32'(fcount_ff);
            end
            if (drsp.done) begin
               mean_in = q_mean;
               state_in = ST_RD_X;
            end
         end
         ST_RD_X: begin
            if (!drsp.busy && !drsp.done) begin
               dreq.start = 1'b1;
               dreq.dividend = 64'((addr_ff - wstart_ff) * 24'(dwidth_ff));
               dreq.divisor = 32'(span);
            end
            if (drsp.done) begin
               x_in = drsp.quotient[DIM_W-1:0];
               state_in = (wmax_ff > wmin_ff && mean_ff > wmin_ff) ? ST_RD_H : ST_DONE;
            end
         end
         ST_RD_H: begin
            if (!drsp.busy && !drsp.done) begin
               dreq.start = 1'b1;
               dreq.dividend = 64'((mean_ff - wmin_ff) * 27'(usable));
               dreq.divisor = 32'(wmax_ff - wmin_ff);
            end
            if (drsp.done) begin
               h_in = (drsp.quotient >= 64'(dheight_ff)) ? dheight_ff
                      : drsp.quotient[DIM_W-1:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            strobe_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State and control registers; reset starts the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         addr_ff <= '0;
         fcount_ff <= '0;
         wmin_ff <= MIN_START;
         wmax_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff <= addr_in;
         fcount_ff <= fcount_in;
         wmin_ff <= wmin_in;
         wmax_ff <= wmax_in;
         strobe_ff <= strobe_in;
      end
      mag_ff <= mag_in;
      mean_ff <= mean_in;
      status_ff <= status_in;
      x_ff <= x_in;
      h_ff <= h_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_status = status_ff;
   assign rsp_x_position = x_ff;
   assign rsp_height = h_ff;
   assign rsp_min_mean = wmin_ff;
   assign rsp_max_mean = wmax_ff;

`ifndef ASSERT_OFF
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy || $past(state_ff) == ST_DONE)
      else $error("strobe outside done");
   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status) |-> (rsp_x_position == '0 && rsp_height == '0))
      else $error("status error with data");
   a_height_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_height <= dheight_ff)
      else $error("height above display");
`endif

endmodule

/* tb/tb_spectrum_average_normalizer_top.sv */
// Testbench for the spectrum average normalizer: directed and random command streams.
// Depends on san_pkg and spectrum_average_normalizer_top; results are checked
// against an in-bench model of the running sums, frame count and min/max walk.
`timescale 1ns / 1ps

module tb_spectrum_average_normalizer_top;
   import san_pkg::*;

   localparam int IDLE_LIMIT = 1200000;

   typedef struct {
      logic             status;
      logic [DIM_W-1:0] x_position;
      logic [DIM_W-1:0] height;
      logic [MEAN_W-1:0] min_mean;
      logic [MEAN_W-1:0] max_mean;
   } bar_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_command;
   logic [BIN_W-1:0]   req_bin_index;
   logic signed [15:0] req_sample;
   logic               csr_write;
   logic [1:0]         csr_index;
   logic [12:0]        csr_data;
   logic               rsp_strobe;
   logic               rsp_status;
   logic [DIM_W-1:0]   rsp_x_position;
   logic [DIM_W-1:0]   rsp_height;
   logic [MEAN_W-1:0]  rsp_min_mean;
   logic [MEAN_W-1:0]  rsp_max_mean;

   // Model state of the averager and its registers.
   bit [31:0] avg_sums [NUM_BINS];
   bit [15:0] avg_frames;
   bit [14:0] avg_min;
   bit [14:0] avg_max;
   bit [11:0] win_start;
   bit [12:0] win_end;
   bit [11:0] disp_width;
   bit [11:0] disp_height;

   bar_type pending_bars[$];
   int      mismatches;
   int      items_sent;
   int      bars_seen;
   int      idle_cycles;

   spectrum_average_normalizer_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_bin_index(req_bin_index), .req_sample(req_sample),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status), .rsp_x_position(rsp_x_position),
      .rsp_height(rsp_height), .rsp_min_mean(rsp_min_mean), .rsp_max_mean(rsp_max_mean)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Window end as the hardware sees it, limited to the bin count.
   function automatic int unsigned window_limit();
      return (win_end < NUM_BINS) ? win_end : NUM_BINS;
   endfunction

   function automatic bit [14:0] bin_mean(int unsigned bin);
      bit [31:0] quotient;
      if (avg_frames == 0) begin
         return 0;
      end
      quotient = avg_sums[bin] / avg_frames;
      return (quotient > 32767) ? 15'd32767 : quotient[14:0];
   endfunction

   // Applies one accepted transaction to the model and queues the bar an end frame or read produces.
   task automatic model_command(cmd_type cmd, int unsigned bin, logic signed [15:0] smp);
      bar_type            bar;
      int unsigned        lim;
      int unsigned        mag;
      longint unsigned    acc;
      longint unsigned    scaled;
      bit [14:0]          mean;
      int unsigned        usable;
      lim = window_limit();
      bar = '{1'b0, '0, '0, '0, '0};
      case (cmd)
         CMD_ACCUM: begin
            if (bin >= win_start && bin < lim) begin
               mag = (smp < 0) ? -int'(smp) : int'(smp);
               acc = longint'(avg_sums[bin]) + mag;
               avg_sums[bin] = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
            end
            return;
         end
         CMD_CLEAR: begin
            foreach (avg_sums[i]) avg_sums[i] = 0;
            avg_frames = 0;
            avg_min = 15'd9999;
            avg_max = 0;
            return;
         end
         CMD_END_FRAME: begin
            if (avg_frames != 16'hFFFF) avg_frames++;
            avg_min = 15'd9999;
            avg_max = 0;
            for (int unsigned i = win_start; i < lim; i++) begin
               mean = bin_mean(i);
               if (mean > avg_max) avg_max = mean;
               if (mean < avg_min) avg_min = mean;
            end
         end
         default: begin
            if (!(bin >= win_start && bin < lim)) begin
               bar.status = 1'b1;
            end else begin
               mean = bin_mean(bin);
               usable = (disp_height >= 2) ? disp_height - 2 : 0;
               scaled = (longint'(bin - win_start) * disp_width) / (lim - win_start);
               bar.x_position = scaled[11:0];
               if (avg_max > avg_min && mean > avg_min) begin
                  scaled = (longint'(mean - avg_min) * usable) / (avg_max - avg_min);
                  bar.height = (scaled >= disp_height) ? disp_height : scaled[11:0];
               end
            end
         end
      endcase
      bar.min_mean = avg_min;
      bar.max_mean = avg_max;
      pending_bars.push_back(bar);
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
      mismatches++;
   endtask

   // Checks every result transaction against the oldest queued bar.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         bars_seen++;
         if (pending_bars.size() == 0) begin
            $display("result transaction with nothing expected");
            mismatches++;
         end else begin
            bar_type want;
            want = pending_bars.pop_front();
            if (rsp_status !== want.status) report_mismatch("status", rsp_status, want.status);
            if (rsp_x_position !== want.x_position)
               report_mismatch("x_position", rsp_x_position, want.x_position);
            if (rsp_height !== want.height) report_mismatch("height", rsp_height, want.height);
            if (rsp_min_mean !== want.min_mean)
               report_mismatch("min_mean", rsp_min_mean, want.min_mean);
            if (rsp_max_mean !== want.max_mean)
               report_mismatch("max_mean", rsp_max_mean, want.max_mean);
         end
      end
   end

   // Ends the run if no transaction moves for too long.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Mostly short gaps, a few long ones, and runs with none.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 0;
      if (roll < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 300);
   endfunction

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sh0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // Sends one command transaction; start may stay high into the next one.
   task automatic send_cmd(cmd_type cmd, int unsigned bin, logic signed [15:0] smp);
      int gap;
      req_command <= cmd;
      req_bin_index <= bin[BIN_W-1:0];
      req_sample <= smp;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      model_command(cmd, bin, smp);
      items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Waits until the block is idle and every bar has come back.
   task automatic drain();
      if (start) start <= 1'b0;
      @(posedge clock);
      while (busy || pending_bars.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(reg_type idx, int unsigned value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value[12:0];
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_WINDOW_START: win_start = value[11:0];
         REG_WINDOW_END: win_end = value[12:0];
         REG_DISPLAY_WIDTH: disp_width = value[11:0];
         default: disp_height = value[11:0];
      endcase
   endtask

   task automatic set_window(int unsigned first, int unsigned past_last);
      drain();
      write_reg(REG_WINDOW_START, first);
      write_reg(REG_WINDOW_END, past_last);
   endtask

   task automatic set_display(int unsigned width, int unsigned height);
      drain();
      write_reg(REG_DISPLAY_WIDTH, width);
      write_reg(REG_DISPLAY_HEIGHT, height);
   endtask

   // Reset values: a read before any frame and one walk over the whole spectrum.
   task automatic test_reset_defaults();
      send_cmd(CMD_READ, 0, 0);
      send_cmd(CMD_ACCUM, 4095, 16'sh8000);
      send_cmd(CMD_ACCUM, 0, 16'sh7FFF);
      send_cmd(CMD_END_FRAME, 0, 0);
      send_cmd(CMD_READ, 4095, 0);
      send_cmd(CMD_READ, 0, 0);
      drain();
   endtask

   // Field extremes, windows edges, clamping and clearing on a small window.
   task automatic test_directed();
      set_window(10, 18);
      set_display(640, 200);
      send_cmd(CMD_CLEAR, 0, 0);
      send_cmd(CMD_READ, 12, 0);
      send_cmd(CMD_ACCUM, 10, 16'sh8000);
      send_cmd(CMD_ACCUM, 10, 16'sh8000);
      send_cmd(CMD_ACCUM, 17, 16'sh7FFF);
      send_cmd(CMD_ACCUM, 11, -16'sd1);
      send_cmd(CMD_ACCUM, 9, 16'sh7FFF);
      send_cmd(CMD_ACCUM, 18, 16'sh7FFF);
      send_cmd(CMD_END_FRAME, 0, 0);
      send_cmd(CMD_READ, 10, 0);
      send_cmd(CMD_READ, 11, 0);
      send_cmd(CMD_READ, 17, 0);
      send_cmd(CMD_READ, 9, 0);
      send_cmd(CMD_READ, 18, 0);
      send_cmd(CMD_END_FRAME, 0, 0);
      send_cmd(CMD_READ, 17, 0);
      send_cmd(CMD_CLEAR, 0, 0);
      send_cmd(CMD_READ, 10, 0);
      drain();
   endtask

   // Single-bin and empty windows, and the display size extremes.
   task automatic test_window_extremes();
      set_window(4095, 4096);
      set_display(4095, 4095);
      send_cmd(CMD_ACCUM, 4095, 16'sh7FFF);
      send_cmd(CMD_END_FRAME, 0, 0);
      send_cmd(CMD_READ, 4095, 0);
      set_window(0, 1);
      set_display(1, 3);
      send_cmd(CMD_ACCUM, 0, 16'sh1234);
      send_cmd(CMD_END_FRAME, 0, 0);
      send_cmd(CMD_READ, 0, 0);
      set_window(100, 50);
      send_cmd(CMD_ACCUM, 75, 16'sh0100);
      send_cmd(CMD_END_FRAME, 0, 0);
      send_cmd(CMD_READ, 75, 0);
      set_window(4090, 8191);
      send_cmd(CMD_ACCUM, 4093, 16'sh4000);
      send_cmd(CMD_END_FRAME, 0, 0);
      send_cmd(CMD_READ, 4093, 0);
      drain();
   endtask

   // Random phases, each with its own window (mostly small) and display size.
   task automatic test_random(int total);
      int unsigned span;
      int unsigned first;
      int unsigned past_last;
      int unsigned bin;
      int          roll;
      int          phase_items;
      while (total > 0) begin
         span = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
         first = $urandom_range(0, 4095);
         past_last = first + span;
         if ($urandom_range(0, 5) == 0) past_last = $urandom_range(0, 8191);
         set_window(first, past_last);
         case ($urandom_range(0, 3))
            0: set_display(1, 3);
            1: set_display(4095, 4095);
            default: set_display($urandom_range(1, 4095), $urandom_range(3, 4095));
         endcase
         span = (window_limit() > win_start) ? window_limit() - win_start : 0;
         phase_items = $urandom_range(30, 70);
         repeat (phase_items) begin
            if (span > 0 && $urandom_range(0, 9) != 0)
               bin = win_start + $urandom_range(0, span - 1);
            else
               bin = $urandom_range(0, 4095);
            roll = $urandom_range(0, 99);
            if (roll < 58) send_cmd(CMD_ACCUM, bin, pick_sample());
            else if (roll < 72)
               send_cmd(CMD_END_FRAME, $urandom_range(0, 4095), 16'($urandom));
            else if (roll < 98) send_cmd(CMD_READ, bin, 16'($urandom));
            else send_cmd(CMD_CLEAR, $urandom_range(0, 4095), 16'($urandom));
         end
         total -= phase_items;
      end
      drain();
   endtask

   initial begin
      foreach (avg_sums[i]) avg_sums[i] = 0;
      avg_frames = 0;
      avg_min = 15'd9999;
      avg_max = 0;
      win_start = 0;
      win_end = 13'd4096;
      disp_width = 12'd640;
      disp_height = 12'd200;
      mismatches = 0;
      items_sent = 0;
      bars_seen = 0;
      idle_cycles = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_command <= CMD_ACCUM;
      req_bin_index <= '0;
      req_sample <= '0;
      csr_write <= 1'b0;
      csr_index <= REG_WINDOW_START;
      csr_data <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_directed();
      test_window_extremes();
      test_random(390);

      drain();
      repeat (300) @(posedge clock);
      if (pending_bars.size() != 0) begin
         $display("%0d expected results never arrived", pending_bars.size());
         mismatches++;
      end
      $display("Sent %0d commands over many window and display settings; checked %0d results.",
               items_sent, bars_seen);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* spectrum_average_normalizer_top.f */
rtl/san_pkg.sv
rtl/san_ram.sv
rtl/san_div.sv
rtl/spectrum_average_normalizer_top.sv
tb/tb_spectrum_average_normalizer_top.sv
